// File: rtl/output_restricted_deque_defines.svh
// assertion macros used by the checker file
`ifndef OUTPUT_RESTRICTED_DEQUE_DEFINES_SVH
`define OUTPUT_RESTRICTED_DEQUE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define ORD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define ORD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ord_pkg.sv
package ord_pkg;

  localparam int DATA_W = 32;

  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_POP        = 2'd2;
  localparam logic [1:0] REQ_PEEK       = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop;
  } ord_cmd_t;

endpackage

// File: rtl/output_restricted_deque.sv
// result: registered, shown in the cycle after its item is accepted
// throughput: one item per cycle unless a result waits untaken; the cell row updates all entries at once
//   and the front cell alone decides pop, peek and the result value
// reset: synchronous, clears every cell's valid bit and the result valid bit,
//   leaving the queue empty; cell data and result fields are not cleared
module output_restricted_deque
  import ord_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [DATA_W-1:0] in_push_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_value,
  output logic [1:0]        out_status,
  output logic              out_is_empty,
  output logic              out_is_full
);

  logic              cell_valid [DEPTH];
  logic [DATA_W-1:0] cell_data  [DEPTH];

  ord_cmd_t cmd;
  logic     accept;
  logic     is_push;
  logic     is_pop;
  logic     is_look;
  logic     push_ok;
  logic     pop_ok;
  logic     look_ok;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;
  logic [1:0]        status_r;
  logic [1:0]        status_nxt;
  logic              empty_r;
  logic              empty_nxt;
  logic              full_r;
  logic              full_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_push = (in_req_type == REQ_PUSH_FRONT) || (in_req_type == REQ_PUSH_BACK);
  assign is_pop  = (in_req_type == REQ_POP);
  assign is_look = is_pop || (in_req_type == REQ_PEEK);

  assign push_ok = is_push && !cell_valid[DEPTH-1];
  assign look_ok = is_look && cell_valid[0];
  assign pop_ok  = is_pop && cell_valid[0];

  assign cmd.push_front = accept && push_ok && (in_req_type == REQ_PUSH_FRONT);
  assign cmd.push_back  = accept && push_ok && (in_req_type == REQ_PUSH_BACK);
  assign cmd.pop        = accept && pop_ok;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              lv;
    logic [DATA_W-1:0] ld;
    logic              rv;
    logic [DATA_W-1:0] rd;

    if (i == 0) begin : g_first
      // the front cell sees a full neighbor carrying the new item
      assign lv = 1'b1;
      assign ld = in_push_value;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_inner
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end

    ord_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .push_value  (in_push_value),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid_o     (cell_valid[i]),
      .data_o      (cell_data[i])
    );
  end

  always_comb begin
    value_nxt  = '0;
    status_nxt = ST_OK;
    if (is_push && !push_ok) begin
      status_nxt = ST_FULL;
    end else if (is_look && !look_ok) begin
      status_nxt = ST_EMPTY;
    end
    if (look_ok) begin
      value_nxt = cell_data[0];
    end
    // flags as they stand once this item has been applied
    priority if (push_ok) begin
      empty_nxt = 1'b0;
      full_nxt  = cell_valid[DEPTH-2];
    end else if (pop_ok) begin
      empty_nxt = !cell_valid[1];
      full_nxt  = 1'b0;
    end else begin
      empty_nxt = !cell_valid[0];
      full_nxt  = cell_valid[DEPTH-1];
    end
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
      empty_r  <= empty_nxt;
      full_r   <= full_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = value_r;
  assign out_status   = status_r;
  assign out_is_empty = empty_r;
  assign out_is_full  = full_r;

endmodule

// File: rtl/ord_cell.sv
module ord_cell
  import ord_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ord_cmd_t          cmd,
  input  logic [DATA_W-1:0] push_value,
  input  logic              left_valid,
  input  logic [DATA_W-1:0] left_data,
  input  logic              right_valid,
  input  logic [DATA_W-1:0] right_data,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic              valid_r;
  logic              valid_nxt;
  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    priority if (cmd.push_front) begin
      // whole row moves one place toward the back
      valid_nxt = left_valid;
      data_nxt  = left_data;
    end else if (cmd.push_back) begin
      // first free cell takes the item
      if (!valid_r && left_valid) begin
        valid_nxt = 1'b1;
        data_nxt  = push_value;
      end
    end else if (cmd.pop) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else begin
      // no command, cell holds
      valid_nxt = valid_r;
      data_nxt  = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// File: rtl/ord_checker.sv
`include "output_restricted_deque_defines.svh"

module ord_checker
  import ord_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_value,
  input logic [1:0]        out_status,
  input logic              out_is_empty,
  input logic              out_is_full
);

  // a waiting result holds until taken
  `ORD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_value) && $stable(out_status),
    "result changed while stalled")

  // every accepted item yields a result on the next cycle
  `ORD_ASSERT_NEXT(a_one_cycle, clk, rst_n, in_valid && in_ready, out_valid,
    "no result after accepted item")

  // a refused push leaves the queue full
  `ORD_ASSERT_IMPL(a_full_flag, clk, rst_n, out_valid && out_status == ST_FULL,
    out_is_full && !out_is_empty && out_value == '0,
    "full refusal with wrong flags")

  // a refused pop or peek shows an empty queue and a zero value
  `ORD_ASSERT_IMPL(a_empty_flag, clk, rst_n, out_valid && out_status == ST_EMPTY,
    out_is_empty && !out_is_full && out_value == '0,
    "empty refusal with wrong flags")

  // empty and full never show together
  `ORD_ASSERT_IMPL(a_flags_excl, clk, rst_n, out_valid, !(out_is_empty && out_is_full),
    "empty and full both set")

endmodule

bind output_restricted_deque ord_checker u_ord_checker (.*);
